// ----- rtl/dafp_pkg.sv -----
// Package: shared constants for the dihedral angle pipeline.
`timescale 1ns / 1ps
package dafp_pkg;
  localparam int NITER   = 26;   // CORDIC iterations
  localparam int SQ_STG  = 32;   // integer square root stages
  localparam int CW      = 36;   // CORDIC x/y width
  localparam int ZW      = 32;   // CORDIC angle accumulator width
  localparam logic signed [ZW-1:0] Z_90  = 32'sd94371840;   // 90 deg in Q.20
  localparam logic signed [ZW-1:0] Z_180 = 32'sd188743680;  // 180 deg in Q.20
  localparam logic [ZW-1:0] ATAN_TAB [NITER] = '{
    32'd47185920, 32'd27855475, 32'd14718068, 32'd7471121, 32'd3750058,
    32'd1876857,  32'd938658,   32'd469357,   32'd234682,  32'd117342,
    32'd58671,    32'd29335,    32'd14668,    32'd7334,    32'd3667,
    32'd1833,     32'd917,      32'd458,      32'd229,     32'd115,
    32'd57,       32'd29,       32'd14,       32'd7,       32'd4,
    32'd2
  };
  localparam int TORS_W = 25;
endpackage

// ----- rtl/dihedral_angle_from_four_points_unit.sv -----
// Top level: fully pipelined dihedral (torsion) angle of four 3-D points.
`timescale 1ns / 1ps
// Takes one quadruple of Q16.16 points per cycle and returns the signed torsion
// angle in Q9.16 degrees (-180..+180), plus a degenerate flag (angle forced to
// 0) when either plane normal is exactly zero. Throughput is one transfer per
// cycle while the output is not stalled. The pipe has 11 stages of exact
// vector arithmetic and normalizing shifts, 32 stages of bit-by-bit integer
// square root, one quadrant pre-rotation stage, 26 CORDIC vectoring stages
// and the output register. The whole pipe holds when the output is stalled,
// so nothing is dropped or repeated; s_tready is high whenever the output
// register is empty or being drained.
module dihedral_angle_from_four_points_unit import dafp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // torsion_deg [24:0], zero pad [31:25]
  output logic [31:0]  m_tdata,
  // degenerate
  output logic [0:0]   m_tuser
);

  localparam int NST = 11 + SQ_STG + 1 + NITER + 1;

  logic adv;
  logic [NST-1:0] vld;

  // shift needed so that the highest set bit lands at or below bit 29
  function automatic logic [5:0] norm_sh(input logic [65:0] v);
    logic [5:0] s;
    s = '0;
    for (int b = 30; b < 66; b++) begin
      if (v[b]) s = 6'(b - 29);
    end
    return s;
  endfunction

  // truncated shifted magnitude with sign restored
  function automatic logic signed [30:0] shrink(input logic [65:0] m, input logic neg,
                                                input logic [5:0] s);
    logic [65:0] t;
    logic signed [30:0] r;
    t = m >> s;
    r = signed'({1'b0, t[29:0]});
    return neg ? -r : r;
  endfunction

  assign adv      = !vld[NST-1] || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // stage 1: difference vectors
  logic signed [31:0] p [12];
  logic signed [32:0] d1 [3], d2a [3], d3 [3];
  always_comb begin
    for (int k = 0; k < 12; k++) p[k] = signed'(s_tdata[32*k +: 32]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1[i]  <= 33'(p[i])     - 33'(p[3+i]);
        d2a[i] <= 33'(p[3+i])   - 33'(p[6+i]);
        d3[i]  <= 33'(p[9+i])   - 33'(p[6+i]);
      end
    end
  end

  // stage 2: cross product terms for both normals
  logic signed [65:0] pa [2][3], pb [2][3];
  logic signed [32:0] d2b [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      pa[0][0] <= d1[1] * d2a[2];  pb[0][0] <= d1[2] * d2a[1];
      pa[0][1] <= d1[2] * d2a[0];  pb[0][1] <= d1[0] * d2a[2];
      pa[0][2] <= d1[0] * d2a[1];  pb[0][2] <= d1[1] * d2a[0];
      pa[1][0] <= d3[1] * d2a[2];  pb[1][0] <= d3[2] * d2a[1];
      pa[1][1] <= d3[2] * d2a[0];  pb[1][1] <= d3[0] * d2a[2];
      pa[1][2] <= d3[0] * d2a[1];  pb[1][2] <= d3[1] * d2a[0];
      d2b <= d2a;
    end
  end

  // stage 3: exact normals
  logic signed [66:0] w [2][3];
  logic signed [32:0] d2c [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 2; n++)
        for (int i = 0; i < 3; i++) w[n][i] <= 67'(pa[n][i]) - 67'(pb[n][i]);
      d2c <= d2b;
    end
  end

  // stage 4: magnitudes and normalizing shift per normal
  logic [65:0] wm [2][3];
  logic        wn [2][3];
  logic [5:0]  wsh [2];
  logic        deg4;
  logic signed [32:0] d2d [3];
  logic [66:0] wabs [2][3];
  logic [65:0] w_or [2];
  always_comb begin
    for (int n = 0; n < 2; n++) begin
      w_or[n] = '0;
      for (int i = 0; i < 3; i++) begin
        wabs[n][i] = w[n][i][66] ? 67'(-w[n][i]) : 67'(w[n][i]);
        w_or[n] = w_or[n] | wabs[n][i][65:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 2; n++) begin
        for (int i = 0; i < 3; i++) begin
          wm[n][i] <= wabs[n][i][65:0];
          wn[n][i] <= w[n][i][66];
        end
        wsh[n] <= norm_sh(w_or[n]);
      end
      deg4 <= (w_or[0] == '0) || (w_or[1] == '0);
      d2d  <= d2c;
    end
  end

  // stage 5: shrunk normals, 31-bit signed
  logic signed [30:0] nv [2][3];
  logic        deg5;
  logic signed [32:0] d2e [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 2; n++)
        for (int i = 0; i < 3; i++) nv[n][i] <= shrink(wm[n][i], wn[n][i], wsh[n]);
      deg5 <= deg4;
      d2e  <= d2d;
    end
  end

  // stage 6: products for c = n1 x n2 and n1 . n2
  logic signed [61:0] ca [3], cb [3], dp [3];
  logic        deg6;
  logic signed [32:0] d2f [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      ca[0] <= nv[0][1] * nv[1][2];  cb[0] <= nv[0][2] * nv[1][1];
      ca[1] <= nv[0][2] * nv[1][0];  cb[1] <= nv[0][0] * nv[1][2];
      ca[2] <= nv[0][0] * nv[1][1];  cb[2] <= nv[0][1] * nv[1][0];
      for (int i = 0; i < 3; i++) dp[i] <= nv[0][i] * nv[1][i];
      deg6 <= deg5;
      d2f  <= d2e;
    end
  end

  // stage 7: c and dot
  logic signed [62:0] cv [3], dotv;
  logic        deg7;
  logic signed [32:0] d2g [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) cv[i] <= 63'(ca[i]) - 63'(cb[i]);
      dotv <= 63'(dp[0]) + 63'(dp[1]) + 63'(dp[2]);
      deg7 <= deg6;
      d2g  <= d2f;
    end
  end

  // stage 8: magnitudes and three normalizing shifts
  logic [61:0] cm [3], dm;
  logic        cn [3], dn;
  logic [32:0] gm [3];
  logic        gn [3];
  logic [5:0]  sh_c, sh_g, sh_4;
  logic        deg8;
  logic [62:0] cabs [3], dabs;
  logic [32:0] gabs [3];
  logic [61:0] cor;
  logic [32:0] gor;
  always_comb begin
    cor = '0;
    gor = '0;
    for (int i = 0; i < 3; i++) begin
      cabs[i] = cv[i][62] ? 63'(-cv[i]) : 63'(cv[i]);
      gabs[i] = d2g[i][32] ? 33'(-d2g[i]) : 33'(d2g[i]);
      cor = cor | cabs[i][61:0];
      gor = gor | gabs[i];
    end
    dabs = dotv[62] ? 63'(-dotv) : 63'(dotv);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cm[i] <= cabs[i][61:0];
        cn[i] <= cv[i][62];
        gm[i] <= gabs[i];
        gn[i] <= d2g[i][32];
      end
      dm   <= dabs[61:0];
      dn   <= dotv[62];
      sh_c <= norm_sh(66'(cor));
      sh_g <= norm_sh(66'(gor));
      sh_4 <= norm_sh(66'(cor | dabs[61:0]));
      deg8 <= deg7;
    end
  end

  // stage 9: shrunk values for sign test and magnitude
  logic signed [30:0] cs [3], gs [3], s4 [4];
  logic        deg9;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cs[i] <= shrink(66'(cm[i]), cn[i], sh_c);
        gs[i] <= shrink(66'(gm[i]), gn[i], sh_g);
        s4[i] <= shrink(66'(cm[i]), cn[i], sh_4);
      end
      s4[3] <= shrink(66'(dm), dn, sh_4);
      deg9  <= deg8;
    end
  end

  // stage 10: products
  logic signed [61:0] sp [3], sq [3];
  logic signed [30:0] x10;
  logic        deg10;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sp[i] <= cs[i] * gs[i];
        sq[i] <= s4[i] * s4[i];
      end
      x10   <= s4[3];
      deg10 <= deg9;
    end
  end

  // stage 11: sign decision and sum of squares, then the square root
  logic signed [63:0] sg;
  logic [63:0] sqsum [SQ_STG+1], sqr [SQ_STG+1];
  logic signed [30:0] sqx [SQ_STG+1];
  logic        sqneg [SQ_STG+1], sqdeg [SQ_STG+1];
  always_comb begin
    sg = 64'(sp[0]) + 64'(sp[1]) + 64'(sp[2]);
  end

  // square root pipeline, one result bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      sqsum[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      sqr[0]   <= '0;
      sqx[0]   <= x10;
      sqneg[0] <= sg > 0;
      sqdeg[0] <= deg10;
      for (int j = 0; j < SQ_STG; j++) begin
        if (sqsum[j] >= sqr[j] + (64'd1 << (62 - 2*j))) begin
          sqsum[j+1] <= sqsum[j] - (sqr[j] + (64'd1 << (62 - 2*j)));
          sqr[j+1]   <= (sqr[j] >> 1) + (64'd1 << (62 - 2*j));
        end else begin
          sqsum[j+1] <= sqsum[j];
          sqr[j+1]   <= sqr[j] >> 1;
        end
        sqx[j+1]   <= sqx[j];
        sqneg[j+1] <= sqneg[j];
        sqdeg[j+1] <= sqdeg[j];
      end
    end
  end

  // quadrant pre-rotation, then CORDIC vectoring
  logic signed [CW-1:0] cx [NITER+1], cy [NITER+1];
  logic signed [ZW-1:0] cz [NITER+1];
  logic        cneg [NITER+1], cdeg [NITER+1];
  logic signed [CW-1:0] x_in, y_in;
  always_comb begin
    x_in = CW'(sqx[SQ_STG]);
    y_in = signed'(CW'(sqr[SQ_STG][31:0]));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (x_in < 0) begin
        cx[0] <= y_in;
        cy[0] <= -x_in;
        cz[0] <= Z_90;
      end else begin
        cx[0] <= x_in;
        cy[0] <= y_in;
        cz[0] <= '0;
      end
      cneg[0] <= sqneg[SQ_STG];
      cdeg[0] <= sqdeg[SQ_STG];
      for (int i = 0; i < NITER; i++) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + signed'(ATAN_TAB[i]);
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - signed'(ATAN_TAB[i]);
        end
        cneg[i+1] <= cneg[i];
        cdeg[i+1] <= cdeg[i];
      end
    end
  end

  // output register: clamp, round to Q16, apply sign, force zero when degenerate
  logic signed [ZW-1:0] zc, zr;
  logic signed [TORS_W-1:0] tors, tors_q;
  logic deg_q;
  always_comb begin
    zc = cz[NITER];
    if (zc < 0) zc = '0;
    if (zc > Z_180) zc = Z_180;
    zr   = (zc + 32'sd8) >>> 4;
    tors = cneg[NITER] ? -zr[TORS_W-1:0] : zr[TORS_W-1:0];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tors_q <= cdeg[NITER] ? '0 : tors;
      deg_q  <= cdeg[NITER];
    end
  end

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = {7'd0, tors_q};
  assign m_tuser  = deg_q;

endmodule

// ----- rtl/dafp_chk.sv -----
// Checker: port-level assertions for the dihedral angle unit, with bind.
`timescale 1ns / 1ps
module dafp_chk import dafp_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [31:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transfer changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("degenerate result with nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:TORS_W] == '0 &&
      $signed(m_tdata[TORS_W-1:0]) >= -25'sd11796480 &&
      $signed(m_tdata[TORS_W-1:0]) <= 25'sd11796480)
    else $error("angle out of range");

endmodule

bind dihedral_angle_from_four_points_unit dafp_chk u_dafp_chk (.*);
